FILE: rtl/core/quicksort_comparison_counter_defines.svh
// Assertion macros for the quicksort comparison counter checker.
`ifndef QUICKSORT_COMPARISON_COUNTER_DEFINES_SVH
`define QUICKSORT_COMPARISON_COUNTER_DEFINES_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define QCC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qcc check failed");

// Antecedent implies consequent in the next cycle, outside reset.
`define QCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qcc check failed");

// Checked through reset as well.
`define QCC_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("qcc reset check failed");

`endif

FILE: rtl/core/qcc_pkg.sv
// Shared types and constants of the quicksort comparison counter.
package qcc_pkg;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_SORT = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [1:0] PVT_LAST_ELEM = 2'd1;
    localparam logic [1:0] PVT_MEDIAN3   = 2'd2;

    localparam logic REG_PIVOT_RULE    = 1'b0;
    localparam logic REG_ELEMENT_COUNT = 1'b1;

    localparam logic [18:0] COUNT_MAX = 19'h7FFFF;

    localparam logic [2:0] RS_HOST = 3'd0;
    localparam logic [2:0] RS_LO   = 3'd1;
    localparam logic [2:0] RS_MID  = 3'd2;
    localparam logic [2:0] RS_LAST = 3'd3;
    localparam logic [2:0] RS_J    = 3'd4;
    localparam logic [2:0] RS_I    = 3'd5;
    localparam logic [2:0] RS_IM1  = 3'd6;

    localparam logic [2:0] WS_HOST  = 3'd0;
    localparam logic [2:0] WS_PIVOT = 3'd1;
    localparam logic [2:0] WS_J     = 3'd2;
    localparam logic [2:0] WS_I     = 3'd3;
    localparam logic [2:0] WS_LO    = 3'd4;
    localparam logic [2:0] WS_IM1   = 3'd5;

    typedef struct packed {
        logic       take_in;
        logic       out_load;
        logic       init;
        logic       pop;
        logic       acc_add;
        logic       ren;
        logic [2:0] rsel;
        logic       wen;
        logic [2:0] wsel;
        logic       cap_f;
        logic       cap_m;
        logic       cap_l;
        logic       set_pivot;
        logic       cap_vj;
        logic       inc_i;
        logic       inc_j;
        logic       split;
        logic       save_cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       sp_zero;
        logic       len_gt1;
        logic       j_lt_hi;
        logic       is_less;
    } dp_stat_t;

endpackage

FILE: rtl/core/quicksort_comparison_counter.sv
// Top level of the quicksort comparison counter.
//
//  channel | dir | contents
//  s_*     | in  | transaction: tuser func; tdata index, value
//  m_*     | out | transaction: tdata read_value, comparison_count; tuser sort_done
//  apb     | in  | registers pivot_rule (0x0), element_count (0x4)
//
// Load and other codes go from exec straight to the output state; read passes
// through a wait state for the registered read data. Sort speed is set by the
// single read port of the element store.
// Reset is synchronous; the element store is not cleared.
// Input is taken only in idle; one result waits in the output register.
module quicksort_comparison_counter #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int STACK_DEPTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // index[9:0], value[41:10], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // read_value[31:0], comparison_count[50:32], zero pad
    output logic [0:0]  m_tuser,   // sort_done[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qcc_pkg::*;

    logic [1:0]  pivot_rule_reg;
    logic [10:0] element_count_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] out_rv;
    logic [18:0] out_cnt;
    logic        out_done;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivot_rule_reg    <= '0;
            element_count_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_PIVOT_RULE) begin
                pivot_rule_reg <= pwdata[1:0];
            end else begin
                element_count_reg <= pwdata[10:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? {21'd0, element_count_reg}
                                                    : {30'd0, pivot_rule_reg};

    qcc_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qcc_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_func        (s_tuser),
        .in_index       (s_tdata[9:0]),
        .in_value       (s_tdata[41:10]),
        .pivot_rule     (pivot_rule_reg),
        .element_count  (element_count_reg),
        .out_read_value (out_rv),
        .out_count      (out_cnt),
        .out_done       (out_done)
    );

    assign m_tdata = {5'd0, out_cnt, out_rv};
    assign m_tuser = out_done;
endmodule

FILE: rtl/core/qcc_ram.sv
// Generic simple dual-port RAM with registered read.
module qcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: rtl/core/qcc_datapath.sv
// Datapath: element store, range stack, scan pointers and comparison counter.
module qcc_datapath #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int STACK_DEPTH  = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  qcc_pkg::dp_cmd_t   cmd,
    output qcc_pkg::dp_stat_t  stat,
    input  logic [1:0]         in_func,
    input  logic [9:0]         in_index,
    input  logic [31:0]        in_value,
    input  logic [1:0]         pivot_rule,
    input  logic [10:0]        element_count,
    output logic [31:0]        out_read_value,
    output logic [18:0]        out_count,
    output logic               out_done
);
    import qcc_pkg::*;

    localparam int AW   = $clog2(MAX_ELEMENTS);
    localparam int PW   = $clog2(MAX_ELEMENTS + 1);
    localparam int SW   = $clog2(STACK_DEPTH + 1);
    localparam int SIW  = $clog2(STACK_DEPTH);
    localparam int SUMW = ((PW > 19) ? PW : 19) + 1;

    logic [1:0]    func_reg;
    logic [9:0]    idx_reg;
    logic [31:0]   val_reg;
    logic [PW-1:0] lo_reg, hi_reg, i_reg, j_reg;
    logic [31:0]   f_reg, m_reg, l_reg, pv_reg, vj_reg;
    logic [PW-1:0] stk_lo_reg [STACK_DEPTH];
    logic [PW-1:0] stk_hi_reg [STACK_DEPTH];
    logic [SW-1:0] sp_reg;
    logic [18:0]   acc_reg, cnt_reg;
    logic [31:0]   out_rv_reg;
    logic [18:0]   out_cnt_reg;
    logic          out_done_reg;

    logic [PW-1:0] len, last, mid, im1, n_sat;
    logic [SW-1:0] spm1;
    logic [SUMW-1:0] sum;
    logic          in_range;
    logic [31:0]   rdata;
    logic          ram_re, ram_we;
    logic [AW-1:0] raddr, waddr;
    logic [31:0]   wdata;
    logic [1:0]    tsel;
    logic [PW-1:0] tpos;
    logic [31:0]   tval;
    logic          le_lm, le_mf, le_fm, le_ml, le_lf, le_fl;

    assign len      = hi_reg - lo_reg;
    assign last     = hi_reg - PW'(1);
    assign mid      = lo_reg + ((len - PW'(1)) >> 1);
    assign im1      = i_reg - PW'(1);
    assign spm1     = sp_reg - SW'(1);
    assign in_range = 32'(idx_reg) < MAX_ELEMENTS;
    assign n_sat    = (32'(element_count) > MAX_ELEMENTS) ? PW'(MAX_ELEMENTS)
                                                         : PW'(element_count);
    assign sum      = SUMW'(acc_reg) + SUMW'(len - PW'(1));

    assign le_lm = $signed(l_reg) <= $signed(m_reg);
    assign le_mf = $signed(m_reg) <= $signed(f_reg);
    assign le_fm = $signed(f_reg) <= $signed(m_reg);
    assign le_ml = $signed(m_reg) <= $signed(l_reg);
    assign le_lf = $signed(l_reg) <= $signed(f_reg);
    assign le_fl = $signed(f_reg) <= $signed(l_reg);

    // tsel: 0 first, 1 middle, 2 last
    always_comb begin
        tsel = 2'd0;
        if (pivot_rule == PVT_LAST_ELEM) begin
            tsel = 2'd2;
        end else if (pivot_rule == PVT_MEDIAN3) begin
            if ((le_lm && le_mf) || (le_fm && le_ml)) begin
                tsel = 2'd1;
            end else if ((le_lf && le_ml) || (le_lm && le_fl)) begin
                tsel = 2'd2;
            end
        end
        case (tsel)
            2'd1:    begin tpos = mid;    tval = m_reg; end
            2'd2:    begin tpos = last;   tval = l_reg; end
            default: begin tpos = lo_reg; tval = f_reg; end
        endcase
    end

    always_comb begin
        case (cmd.rsel)
            RS_LO:   raddr = AW'(lo_reg);
            RS_MID:  raddr = AW'(mid);
            RS_LAST: raddr = AW'(last);
            RS_J:    raddr = AW'(j_reg);
            RS_I:    raddr = AW'(i_reg);
            RS_IM1:  raddr = AW'(im1);
            default: raddr = AW'(idx_reg);
        endcase
        case (cmd.wsel)
            WS_PIVOT: begin waddr = AW'(tpos);  wdata = f_reg;  end
            WS_J:     begin waddr = AW'(j_reg); wdata = rdata;  end
            WS_I:     begin waddr = AW'(i_reg); wdata = vj_reg; end
            WS_LO:    begin waddr = AW'(lo_reg); wdata = rdata; end
            WS_IM1:   begin waddr = AW'(im1);   wdata = pv_reg; end
            default:  begin waddr = AW'(idx_reg); wdata = val_reg; end
        endcase
    end

    assign ram_re = cmd.ren && ((cmd.rsel != RS_HOST) || in_range);
    assign ram_we = cmd.wen && ((cmd.wsel != WS_HOST) || in_range);

    qcc_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            func_reg <= in_func;
            idx_reg  <= in_index;
            val_reg  <= in_value;
        end
        if (cmd.cap_f)  f_reg  <= rdata;
        if (cmd.cap_m)  m_reg  <= rdata;
        if (cmd.cap_l)  l_reg  <= rdata;
        if (cmd.cap_vj) vj_reg <= rdata;
        if (cmd.set_pivot) begin
            pv_reg <= tval;
            i_reg  <= lo_reg + PW'(1);
            j_reg  <= lo_reg + PW'(1);
        end
        if (cmd.inc_i) i_reg <= i_reg + PW'(1);
        if (cmd.inc_j) j_reg <= j_reg + PW'(1);
        if (cmd.pop) begin
            lo_reg <= stk_lo_reg[spm1[SIW-1:0]];
            hi_reg <= stk_hi_reg[spm1[SIW-1:0]];
        end
        if (cmd.init) begin
            stk_lo_reg[0] <= '0;
            stk_hi_reg[0] <= n_sat;
        end
        if (cmd.split) begin
            if ((im1 - lo_reg) >= (hi_reg - i_reg)) begin
                if (sp_reg < SW'(STACK_DEPTH)) begin
                    stk_lo_reg[sp_reg[SIW-1:0]] <= lo_reg;
                    stk_hi_reg[sp_reg[SIW-1:0]] <= im1;
                end
                lo_reg <= i_reg;
            end else begin
                if (sp_reg < SW'(STACK_DEPTH)) begin
                    stk_lo_reg[sp_reg[SIW-1:0]] <= i_reg;
                    stk_hi_reg[sp_reg[SIW-1:0]] <= hi_reg;
                end
                hi_reg <= im1;
            end
        end
        if (cmd.out_load) begin
            out_rv_reg   <= ((func_reg == FUNC_READ) && in_range) ? rdata : 32'd0;
            out_cnt_reg  <= cnt_reg;
            out_done_reg <= (func_reg == FUNC_SORT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg  <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.init) begin
                sp_reg  <= SW'(1);
                acc_reg <= '0;
            end else if (cmd.pop) begin
                sp_reg <= spm1;
            end else if (cmd.split && (sp_reg < SW'(STACK_DEPTH))) begin
                sp_reg <= sp_reg + SW'(1);
            end
            if (cmd.acc_add) begin
                acc_reg <= (sum > SUMW'(COUNT_MAX)) ? COUNT_MAX : sum[18:0];
            end
            if (cmd.save_cnt) begin
                cnt_reg <= acc_reg;
            end
        end
    end

    assign stat.func    = func_reg;
    assign stat.sp_zero = (sp_reg == '0);
    assign stat.len_gt1 = (len > PW'(1));
    assign stat.j_lt_hi = (j_reg < hi_reg);
    assign stat.is_less = $signed(rdata) < $signed(pv_reg);

    assign out_read_value = out_rv_reg;
    assign out_count      = out_cnt_reg;
    assign out_done       = out_done_reg;
endmodule

FILE: rtl/core/qcc_controller.sv
// Controller: sequences host transactions and the quicksort partition passes.
module qcc_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  qcc_pkg::dp_stat_t stat,
    output qcc_pkg::dp_cmd_t  cmd
);
    import qcc_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_EXEC  = 5'd1;
    localparam logic [4:0] S_RDW   = 5'd2;
    localparam logic [4:0] S_OUT   = 5'd3;
    localparam logic [4:0] S_INIT  = 5'd4;
    localparam logic [4:0] S_POP   = 5'd5;
    localparam logic [4:0] S_RANGE = 5'd6;
    localparam logic [4:0] S_RD_M  = 5'd7;
    localparam logic [4:0] S_RD_L  = 5'd8;
    localparam logic [4:0] S_CAP_L = 5'd9;
    localparam logic [4:0] S_SEL   = 5'd10;
    localparam logic [4:0] S_SCAN  = 5'd11;
    localparam logic [4:0] S_CMP   = 5'd12;
    localparam logic [4:0] S_SW1   = 5'd13;
    localparam logic [4:0] S_SW2   = 5'd14;
    localparam logic [4:0] S_END1  = 5'd15;
    localparam logic [4:0] S_END2  = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        mvalid_next = m_tready ? 1'b0 : mvalid_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (stat.func)
                    FUNC_LOAD: begin
                        cmd.wen    = 1'b1;
                        cmd.wsel   = WS_HOST;
                        state_next = S_OUT;
                    end
                    FUNC_READ: begin
                        cmd.ren    = 1'b1;
                        cmd.rsel   = RS_HOST;
                        state_next = S_RDW;
                    end
                    FUNC_SORT: state_next = S_INIT;
                    default:   state_next = S_OUT;
                endcase
            end
            S_RDW: state_next = S_OUT;
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_INIT: begin
                cmd.init   = 1'b1;
                state_next = S_POP;
            end
            S_POP: begin
                if (stat.sp_zero) begin
                    state_next = S_FIN;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = S_RANGE;
                end
            end
            S_RANGE: begin
                if (!stat.len_gt1) begin
                    state_next = S_POP;
                end else begin
                    cmd.acc_add = 1'b1;
                    cmd.ren     = 1'b1;
                    cmd.rsel    = RS_LO;
                    state_next  = S_RD_M;
                end
            end
            S_RD_M: begin
                cmd.cap_f  = 1'b1;
                cmd.ren    = 1'b1;
                cmd.rsel   = RS_MID;
                state_next = S_RD_L;
            end
            S_RD_L: begin
                cmd.cap_m  = 1'b1;
                cmd.ren    = 1'b1;
                cmd.rsel   = RS_LAST;
                state_next = S_CAP_L;
            end
            S_CAP_L: begin
                cmd.cap_l  = 1'b1;
                state_next = S_SEL;
            end
            S_SEL: begin
                // pivot slot takes the first element; pivot value held aside
                cmd.set_pivot = 1'b1;
                cmd.wen       = 1'b1;
                cmd.wsel      = WS_PIVOT;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                cmd.ren = 1'b1;
                if (stat.j_lt_hi) begin
                    cmd.rsel   = RS_J;
                    state_next = S_CMP;
                end else begin
                    cmd.rsel   = RS_IM1;
                    state_next = S_END1;
                end
            end
            S_CMP: begin
                if (stat.is_less) begin
                    cmd.cap_vj = 1'b1;
                    cmd.ren    = 1'b1;
                    cmd.rsel   = RS_I;
                    state_next = S_SW1;
                end else begin
                    cmd.inc_j  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SW1: begin
                cmd.wen    = 1'b1;
                cmd.wsel   = WS_J;
                state_next = S_SW2;
            end
            S_SW2: begin
                cmd.wen    = 1'b1;
                cmd.wsel   = WS_I;
                cmd.inc_i  = 1'b1;
                cmd.inc_j  = 1'b1;
                state_next = S_SCAN;
            end
            S_END1: begin
                cmd.wen    = 1'b1;
                cmd.wsel   = WS_LO;
                state_next = S_END2;
            end
            S_END2: begin
                cmd.wen    = 1'b1;
                cmd.wsel   = WS_IM1;
                cmd.split  = 1'b1;
                state_next = S_RANGE;
            end
            S_FIN: begin
                cmd.save_cnt = 1'b1;
                state_next   = S_OUT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
endmodule

FILE: rtl/core/qcc_checker.sv
// Port-level checker for the quicksort comparison counter, bound to the top level.
`include "quicksort_comparison_counter_defines.svh"

module qcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser
);
    `QCC_ASSERT_RESET(a_reset_no_result, !aresetn, !m_tvalid)
    `QCC_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `QCC_ASSERT_IMPL(a_sort_no_read_data, m_tvalid && m_tuser[0], m_tdata[31:0] == 32'd0)
    `QCC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
endmodule

bind quicksort_comparison_counter qcc_checker u_qcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
